// File: hw/rtl/sorted_tlb_invalidation_batcher_assert.svh
// Assertion macros shared by the invalidation batcher RTL.
// Expects signals named clk and rst_n in the including module.
`ifndef SORTED_TLB_INVALIDATION_BATCHER_ASSERT_SVH
`define SORTED_TLB_INVALIDATION_BATCHER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define STIB_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stib: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define STIB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stib: next-cycle check failed");

`endif

// File: hw/rtl/stib_pkg.sv
// Types and constants of the sorted invalidation batcher.
// No dependencies.
package stib_pkg;

    localparam int VADDR_W  = 64;
    localparam int TAG_W    = 12;
    localparam int TARGET_W = 8;
    localparam int STATUS_W = 3;
    localparam int TOTAL_W  = 32;

    typedef enum logic [0:0] {
        REQ_QUEUE = 1'b0,
        REQ_DRAIN = 1'b1
    } req_kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_QUEUED     = 3'd0,
        STAT_BAD_TARGET = 3'd1,
        STAT_MISALIGNED = 3'd2,
        STAT_FULL       = 3'd3,
        STAT_APPLIED    = 3'd4,
        STAT_EMPTY      = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CNT,
        ST_INS,
        ST_INS_LAST,
        ST_DRN,
        ST_RESP
    } state_t;

endpackage

// File: hw/rtl/stib_req_if.sv
// Request channel of the invalidation batcher: valid/ready plus request fields.
// Depends on stib_pkg.
interface stib_req_if;
    logic                          valid;
    logic                          ready;
    logic                          req_type;
    logic [stib_pkg::TARGET_W-1:0] target;
    logic [stib_pkg::VADDR_W-1:0]  vaddr;
    logic [stib_pkg::TAG_W-1:0]    space_tag;

    modport source (output valid, req_type, target, vaddr, space_tag, input ready);
    modport sink   (input valid, req_type, target, vaddr, space_tag, output ready);
endinterface

// File: hw/rtl/stib_rsp_if.sv
// Result channel of the invalidation batcher: valid/ready plus result fields.
// Depends on stib_pkg.
interface stib_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [stib_pkg::STATUS_W-1:0] status;
    logic [stib_pkg::VADDR_W-1:0]  out_vaddr;
    logic [stib_pkg::TAG_W-1:0]    out_tag;
    logic                          last;
    logic [stib_pkg::TOTAL_W-1:0]  applied_total;

    modport source (output valid, status, out_vaddr, out_tag, last, applied_total,
                    input ready);
    modport sink   (input valid, status, out_vaddr, out_tag, last, applied_total,
                    output ready);
endinterface

// File: hw/rtl/stib_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module stib_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/sorted_tlb_invalidation_batcher.sv
// Sorted invalidation batcher top level: sequencer, entry store and count store.
// Depends on stib_pkg, stib_req_if, stib_rsp_if, stib_ram and the assert header.
//
// The block keeps one batch of page-invalidation entries per target processor,
// each batch sorted ascending by address, in a single entry RAM of
// MAX_CPUS*BATCH_DEPTH rows and a small count RAM with one valid bit per
// target (a target whose bit is clear holds no entries). A request beat is
// taken only while the sequencer is idle. A queue request that is rejected
// (bad target, misaligned address) goes straight to the response state; a
// full check needs the count read first, as does a queue into an empty
// batch. Any other accepted queue request reads the count, then moves up one
// slot each entry that is larger than the new address, because one 64-bit
// comparator walks down the batch reading one entry and writing one entry per
// cycle. A drain first reads the count and then the first entry, and then
// emits one result beat per cycle while the sink is ready. A result waiting
// in the output register does not stop the next request from being taken.
`include "sorted_tlb_invalidation_batcher_assert.svh"

module sorted_tlb_invalidation_batcher #(
    parameter int MAX_CPUS    = 8,
    parameter int BATCH_DEPTH = 16,
    parameter int PAGE_BITS   = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    stib_req_if.sink    req,
    stib_rsp_if.source  rsp
);

    localparam int TW   = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
    localparam int CW   = $clog2(BATCH_DEPTH + 1);
    localparam int NENT = MAX_CPUS * BATCH_DEPTH;
    localparam int AW   = (NENT > 1) ? $clog2(NENT) : 1;
    localparam int VW   = stib_pkg::VADDR_W;
    localparam int GW   = stib_pkg::TAG_W;
    localparam int EW   = VW + GW;
    localparam logic [VW-1:0] PAGE_MASK = (64'd1 << PAGE_BITS) - 64'd1;

    // Control state.
    stib_pkg::state_t      state_reg, state_next;
    logic [MAX_CPUS-1:0]   cnt_valid_reg, cnt_valid_next;
    logic                  rd_pend_reg, rd_pend_next;
    logic                  out_valid_reg, out_valid_next;
    logic [stib_pkg::TOTAL_W-1:0] applied_reg, applied_next;

    // Payload of the request in flight.
    stib_pkg::req_kind_t   kind_reg, kind_next;
    logic [TW-1:0]         tgt_reg, tgt_next;
    logic [VW-1:0]         va_reg, va_next;
    logic [GW-1:0]         tag_reg, tag_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [CW-1:0]         pos_reg, pos_next;
    logic [CW-1:0]         emit_reg, emit_next;
    stib_pkg::status_t     rsp_stat_reg, rsp_stat_next;

    // Output register.
    stib_pkg::status_t     out_status_reg, out_status_next;
    logic [VW-1:0]         out_vaddr_reg, out_vaddr_next;
    logic [GW-1:0]         out_tag_reg, out_tag_next;
    logic                  out_last_reg, out_last_next;
    logic [stib_pkg::TOTAL_W-1:0] out_total_reg, out_total_next;

    // RAM ports.
    logic          ent_we, ent_re;
    logic [AW-1:0] ent_waddr, ent_raddr;
    logic [EW-1:0] ent_wdata, ent_rdata;
    logic          cnt_we, cnt_re;
    logic [TW-1:0] cnt_waddr, cnt_raddr;
    logic [CW-1:0] cnt_wdata, cnt_rdata;

    // Decode and shared helpers.
    logic          accept;
    logic          bad_target;
    logic          misaligned;
    logic [CW-1:0] cnt_cur;
    logic [AW-1:0] tgt_base;
    logic [VW-1:0] rd_vaddr;
    logic [GW-1:0] rd_tag;
    logic          rd_greater;
    logic          out_free;
    logic          out_load;
    logic          load_last;

    assign req.ready  = (state_reg == stib_pkg::ST_IDLE);
    assign accept     = req.valid && req.ready;
    assign bad_target = ({1'b0, req.target} >= 9'(MAX_CPUS));
    assign misaligned = ((req.vaddr & PAGE_MASK) != '0);

    // A target whose valid bit is clear has never been written since reset.
    assign cnt_cur    = cnt_valid_reg[tgt_reg] ? cnt_rdata : '0;
    assign tgt_base   = AW'(tgt_reg) * AW'(BATCH_DEPTH);

    assign rd_vaddr   = ent_rdata[EW-1 -: VW];
    assign rd_tag     = ent_rdata[GW-1:0];
    // The one address comparator of the design: is the entry below the hole larger?
    assign rd_greater = (rd_vaddr > va_reg);

    assign out_free   = !out_valid_reg || rsp.ready;
    assign out_load   = (state_reg == stib_pkg::ST_DRN) && rd_pend_reg && out_free;
    assign load_last  = (emit_reg == (cnt_reg - CW'(1)));

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            stib_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (bad_target)
                    begin
                        state_next = stib_pkg::ST_RESP;
                    end
                    else if ((req.req_type == stib_pkg::REQ_QUEUE) && misaligned)
                    begin
                        state_next = stib_pkg::ST_RESP;
                    end
                    else
                    begin
                        state_next = stib_pkg::ST_CNT;
                    end
                end
            end
            stib_pkg::ST_CNT:
            begin
                if (kind_reg == stib_pkg::REQ_QUEUE)
                begin
                    if ((cnt_cur >= CW'(BATCH_DEPTH)) || (cnt_cur == '0))
                    begin
                        state_next = stib_pkg::ST_RESP;
                    end
                    else
                    begin
                        state_next = stib_pkg::ST_INS;
                    end
                end
                else if (cnt_cur == '0)
                begin
                    state_next = stib_pkg::ST_RESP;
                end
                else
                begin
                    state_next = stib_pkg::ST_DRN;
                end
            end
            stib_pkg::ST_INS:
            begin
                if (!rd_greater)
                begin
                    state_next = stib_pkg::ST_RESP;
                end
                else if (pos_reg == CW'(1))
                begin
                    state_next = stib_pkg::ST_INS_LAST;
                end
            end
            stib_pkg::ST_INS_LAST:
            begin
                state_next = stib_pkg::ST_RESP;
            end
            stib_pkg::ST_DRN:
            begin
                if (out_load && load_last)
                begin
                    state_next = stib_pkg::ST_IDLE;
                end
            end
            stib_pkg::ST_RESP:
            begin
                if (out_free)
                begin
                    state_next = stib_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = stib_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath, memory controls and output register.
    always_comb
    begin
        cnt_valid_next  = cnt_valid_reg;
        rd_pend_next    = rd_pend_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        applied_next    = applied_reg;
        kind_next       = kind_reg;
        tgt_next        = tgt_reg;
        va_next         = va_reg;
        tag_next        = tag_reg;
        cnt_next        = cnt_reg;
        pos_next        = pos_reg;
        emit_next       = emit_reg;
        rsp_stat_next   = rsp_stat_reg;
        out_status_next = out_status_reg;
        out_vaddr_next  = out_vaddr_reg;
        out_tag_next    = out_tag_reg;
        out_last_next   = out_last_reg;
        out_total_next  = out_total_reg;

        ent_we    = 1'b0;
        ent_waddr = tgt_base + AW'(pos_reg);
        ent_wdata = {va_reg, tag_reg};
        ent_re    = 1'b0;
        ent_raddr = tgt_base + AW'(pos_reg);
        cnt_we    = 1'b0;
        cnt_waddr = tgt_reg;
        cnt_wdata = cnt_reg + CW'(1);
        cnt_re    = 1'b0;
        cnt_raddr = req.target[TW-1:0];

        case (state_reg)
            stib_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    kind_next = stib_pkg::req_kind_t'(req.req_type);
                    tgt_next  = req.target[TW-1:0];
                    va_next   = req.vaddr;
                    tag_next  = req.space_tag;
                    cnt_re    = 1'b1;
                    if (bad_target)
                    begin
                        rsp_stat_next = stib_pkg::STAT_BAD_TARGET;
                    end
                    else
                    begin
                        rsp_stat_next = stib_pkg::STAT_MISALIGNED;
                    end
                end
            end
            stib_pkg::ST_CNT:
            begin
                cnt_next = cnt_cur;
                if (kind_reg == stib_pkg::REQ_QUEUE)
                begin
                    if (cnt_cur >= CW'(BATCH_DEPTH))
                    begin
                        rsp_stat_next = stib_pkg::STAT_FULL;
                    end
                    else if (cnt_cur == '0)
                    begin
                        // Empty batch: the new entry goes straight to slot zero.
                        ent_we         = 1'b1;
                        ent_waddr      = tgt_base;
                        cnt_we         = 1'b1;
                        cnt_wdata      = CW'(1);
                        cnt_valid_next = cnt_valid_reg | (MAX_CPUS'(1) << tgt_reg);
                        rsp_stat_next  = stib_pkg::STAT_QUEUED;
                    end
                    else
                    begin
                        pos_next  = cnt_cur;
                        ent_re    = 1'b1;
                        ent_raddr = tgt_base + AW'(cnt_cur - CW'(1));
                    end
                end
                else
                begin
                    rsp_stat_next = stib_pkg::STAT_EMPTY;
                    pos_next      = '0;
                    emit_next     = '0;
                    rd_pend_next  = 1'b0;
                end
            end
            stib_pkg::ST_INS:
            begin
                // The entry at pos-1 is in the read register; pos is the hole.
                ent_we = 1'b1;
                if (rd_greater)
                begin
                    ent_wdata = ent_rdata;
                    pos_next  = pos_reg - CW'(1);
                    if (pos_reg != CW'(1))
                    begin
                        ent_re    = 1'b1;
                        ent_raddr = tgt_base + AW'(pos_reg - CW'(2));
                    end
                end
                else
                begin
                    cnt_we         = 1'b1;
                    cnt_valid_next = cnt_valid_reg | (MAX_CPUS'(1) << tgt_reg);
                    rsp_stat_next  = stib_pkg::STAT_QUEUED;
                end
            end
            stib_pkg::ST_INS_LAST:
            begin
                ent_we         = 1'b1;
                ent_waddr      = tgt_base;
                cnt_we         = 1'b1;
                cnt_valid_next = cnt_valid_reg | (MAX_CPUS'(1) << tgt_reg);
                rsp_stat_next  = stib_pkg::STAT_QUEUED;
            end
            stib_pkg::ST_DRN:
            begin
                // pos_reg is the next row to read, emit_reg the next to send.
                if ((pos_reg < cnt_reg) && (!rd_pend_reg || out_load))
                begin
                    ent_re       = 1'b1;
                    pos_next     = pos_reg + CW'(1);
                    rd_pend_next = 1'b1;
                end
                else if (out_load)
                begin
                    rd_pend_next = 1'b0;
                end
                if (out_load)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = stib_pkg::STAT_APPLIED;
                    out_vaddr_next  = rd_vaddr;
                    out_tag_next    = rd_tag;
                    out_last_next   = load_last;
                    out_total_next  = applied_reg + 32'd1;
                    applied_next    = applied_reg + 32'd1;
                    emit_next       = emit_reg + CW'(1);
                    if (load_last)
                    begin
                        cnt_we    = 1'b1;
                        cnt_wdata = '0;
                    end
                end
            end
            stib_pkg::ST_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = rsp_stat_reg;
                    out_vaddr_next  = '0;
                    out_tag_next    = '0;
                    out_last_next   = 1'b1;
                    out_total_next  = applied_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= stib_pkg::ST_IDLE;
            cnt_valid_reg <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            applied_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_valid_reg <= cnt_valid_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
            applied_reg   <= applied_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        tgt_reg        <= tgt_next;
        va_reg         <= va_next;
        tag_reg        <= tag_next;
        cnt_reg        <= cnt_next;
        pos_reg        <= pos_next;
        emit_reg       <= emit_next;
        rsp_stat_reg   <= rsp_stat_next;
        out_status_reg <= out_status_next;
        out_vaddr_reg  <= out_vaddr_next;
        out_tag_reg    <= out_tag_next;
        out_last_reg   <= out_last_next;
        out_total_reg  <= out_total_next;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.out_vaddr     = out_vaddr_reg;
    assign rsp.out_tag       = out_tag_reg;
    assign rsp.last          = out_last_reg;
    assign rsp.applied_total = out_total_reg;

    // Entry store: address and tag of every slot of every batch.
    stib_ram #(
        .WIDTH (EW),
        .DEPTH (NENT)
    ) u_ent_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .re    (ent_re),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    // Count store: number of entries held per target.
    stib_ram #(
        .WIDTH (CW),
        .DEPTH (MAX_CPUS)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (cnt_re),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    // A batch never claims more entries than it has slots.
    `STIB_ASSERT_IMPL(a_cnt_bound, cnt_we, cnt_wdata <= CW'(BATCH_DEPTH))
    // The insertion walk always has a slot below the hole to look at.
    `STIB_ASSERT_IMPL(a_ins_pos, state_reg == stib_pkg::ST_INS, pos_reg != '0)
    // The shift writes the hole while reading the row two below it, never the same row.
    `STIB_ASSERT_IMPL(a_ins_ports, ent_we && ent_re, ent_waddr != ent_raddr)
    // Sending the last drained entry ends the drain with a result on the port.
    `STIB_ASSERT_NEXT(a_drain_end, out_load && load_last, state_reg == stib_pkg::ST_IDLE && rsp.valid)

endmodule
